>>> rtl/dcd_pkg.sv
`timescale 1ns / 1ps

package dcd_pkg;

    // Input field and intermediate widths
    localparam int DAYS_W     = 16;
    localparam int SHIFT_W    = 17;  // day count after the 366-day shift
    localparam int CYCLE_W    = 6;   // four-year cycle index, at most 45
    localparam int REM_W      = 11;  // day within a four-year span, below 1461
    localparam int YDAY_W     = 9;   // day within a year, 0..365
    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DOM_W      = 5;
    localparam int WDAY_W     = 3;

    localparam logic [SHIFT_W-1:0] SHIFT_DAYS = 17'd366;
    localparam logic [SHIFT_W-1:0] CYCLE_DAYS = 17'd1461;
    localparam logic [YEAR_W-1:0]  BASE_YEAR  = 12'd1968;

    // Reciprocal of 1461 scaled by 2^26; exact for every shifted count below 94519
    localparam int                 RECIP_SHIFT = 26;
    localparam logic [15:0]        RECIP_1461  = 16'd45934;

    // Year boundaries inside a four-year cycle
    localparam logic [REM_W-1:0]   YEAR1_START = 11'd365;
    localparam logic [REM_W-1:0]   YEAR2_START = 11'd730;
    localparam logic [REM_W-1:0]   YEAR3_START = 11'd1095;

    // Weekday offset: (count + 366 + 2) mod 7 == (count + 4) mod 7
    localparam logic [5:0]         WDAY_OFFSET = 6'd4;
    localparam logic [3:0]         WDAY_MOD    = 4'd7;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
    localparam logic [DOM_W-1:0]   DAY_DEC_LAST = 5'd31;

    // Cumulative month ends of a common year
    localparam logic [YDAY_W-1:0] MONTH_END_COMMON [12] = '{
        9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

endpackage

>>> rtl/dcd_month_lookup.sv
`timescale 1ns / 1ps

// Day-of-year to month / day-of-month. Day 0 maps to 31 December.
module dcd_month_lookup import dcd_pkg::*; (
    input  logic [YDAY_W-1:0]  yday,
    input  logic               leap,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day
);

    logic [YDAY_W-1:0] month_end [12];
    logic [YDAY_W-1:0] month_prev [12];
    logic [11:0]       hit;

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            month_end[i] = MONTH_END_COMMON[i] +
                           ((i >= 1) ? {{(YDAY_W-1){1'b0}}, leap} : {YDAY_W{1'b0}});
        end
        month_prev[0] = '0;
        for (int i = 1; i < 12; i++) begin
            month_prev[i] = month_end[i-1];
        end
        for (int i = 0; i < 12; i++) begin
            hit[i] = (yday <= month_end[i]);
        end
    end

    // Lowest matching month wins; scan from the top so it overwrites last
    always_comb begin
        month = MONTH_DEC;
        day   = DAY_DEC_LAST;
        if (yday != '0) begin
            for (int i = 11; i >= 0; i--) begin
                if (hit[i]) begin
                    month = MONTH_W'(i);
                    day   = DOM_W'(yday - month_prev[i]);
                end
            end
        end
    end

endmodule

>>> rtl/day_count_to_calendar_date_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                          Dir  Beat
// -------   ---------------------------------------------  ---  ----------------------------
// input     s_valid s_ready s_days_since_epoch[15:0]       in   one day count since 1970-01-01
// result    m_valid m_ready m_year[11:0] m_month[3:0]      out  one calendar date per beat
//           m_day_of_month[4:0] m_weekday[2:0]
//
// Pipeline: four register stages, stage 1 to stage 4; m_valid is the stage 4 valid bit. One
//   beat per cycle sustained while m_ready stays high, since every stage takes a new beat
//   each cycle it is not held; the reciprocal multiply in stage 1 is the deepest path.
// Reset: aresetn synchronous, active low; clears only the stage valid bits.
// Stalls: each stage holds while the stage after it is full and blocked, so a low
//   m_ready backs up one stage at a time and empty stages keep taking new beats.
// Leap rule: every fourth year from 1972 is a leap year, 2100 included.
module day_count_to_calendar_date_unit import dcd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DAYS_W-1:0]  s_days_since_epoch,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [YEAR_W-1:0]  m_year,
    output logic [MONTH_W-1:0] m_month,
    output logic [DOM_W-1:0]   m_day_of_month,
    output logic [WDAY_W-1:0]  m_weekday
);

    // ---------------- stage valids and advance ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: shift, divide by 1461, weekday fold ----------------
    // Shift so 1 Jan 1969 is day 1; cycle index via reciprocal multiply.
    logic [SHIFT_W-1:0]   shifted;
    logic [32:0]          recip_prod;
    logic [5:0]           wfold_next;
    logic [SHIFT_W-1:0]   shifted_reg;
    logic [CYCLE_W-1:0]   cycle_next, cycle1_reg;
    logic [5:0]           wfold_reg;

    assign shifted    = {1'b0, s_days_since_epoch} + SHIFT_DAYS;
    assign recip_prod = shifted * RECIP_1461;
    assign cycle_next = recip_prod[RECIP_SHIFT +: CYCLE_W];

    // 8 == 1 mod 7: sum of octal digits keeps the residue
    assign wfold_next = 6'(s_days_since_epoch[2:0])   + 6'(s_days_since_epoch[5:3])
                      + 6'(s_days_since_epoch[8:6])   + 6'(s_days_since_epoch[11:9])
                      + 6'(s_days_since_epoch[14:12]) + 6'(s_days_since_epoch[15])
                      + WDAY_OFFSET;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            shifted_reg <= shifted;
            cycle1_reg  <= cycle_next;
            wfold_reg   <= wfold_next;
        end
    end

    // ---------------- stage 2: remainder in cycle, weekday finish ----------------
    logic [SHIFT_W-1:0] cycle_base;
    logic [SHIFT_W-1:0] rem_full;
    logic [3:0]         wsum;
    logic [WDAY_W-1:0]  wday_next;
    logic [REM_W-1:0]   rem_reg;
    logic [CYCLE_W-1:0] cycle2_reg;
    logic [WDAY_W-1:0]  wday2_reg;

    assign cycle_base = SHIFT_W'({{(SHIFT_W-CYCLE_W){1'b0}}, cycle1_reg} * CYCLE_DAYS);
    assign rem_full   = shifted_reg - cycle_base;
    assign wsum       = 4'(wfold_reg[5:3]) + 4'(wfold_reg[2:0]);
    assign wday_next  = (wsum >= WDAY_MOD) ? WDAY_W'(wsum - WDAY_MOD) : WDAY_W'(wsum);

    always_ff @(posedge aclk) begin
        if (adv2) begin
            rem_reg    <= rem_full[REM_W-1:0];
            cycle2_reg <= cycle1_reg;
            wday2_reg  <= wday_next;
        end
    end

    // ---------------- stage 3: year in cycle (capped at 3), day in year ----------------
    logic [1:0]         yidx;
    logic [REM_W-1:0]   year_start;
    logic [REM_W-1:0]   yday_full;
    logic [YEAR_W-1:0]  year_base_next;
    logic [YDAY_W-1:0]  yday_reg;
    logic               leap_reg;
    logic [YEAR_W-1:0]  year_base_reg;
    logic [WDAY_W-1:0]  wday3_reg;

    always_comb begin
        if (rem_reg >= YEAR3_START) begin
            yidx       = 2'd3;
            year_start = YEAR3_START;
        end else if (rem_reg >= YEAR2_START) begin
            yidx       = 2'd2;
            year_start = YEAR2_START;
        end else if (rem_reg >= YEAR1_START) begin
            yidx       = 2'd1;
            year_start = YEAR1_START;
        end else begin
            yidx       = 2'd0;
            year_start = '0;
        end
    end

    assign yday_full      = rem_reg - year_start;
    // 4 * cycle + year index is just the concatenation
    assign year_base_next = YEAR_W'({cycle2_reg, yidx}) + BASE_YEAR;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            yday_reg      <= yday_full[YDAY_W-1:0];
            leap_reg      <= (yidx == 2'd3);
            year_base_reg <= year_base_next;
            wday3_reg     <= wday2_reg;
        end
    end

    // ---------------- stage 4: month lookup, output register ----------------
    // Day 0 of a year is 31 December of the year before, so no +1 there.
    logic [MONTH_W-1:0] month_next;
    logic [DOM_W-1:0]   dom_next;
    logic [YEAR_W-1:0]  year_next;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DOM_W-1:0]   dom_reg;
    logic [WDAY_W-1:0]  wday4_reg;

    dcd_month_lookup u_month (
        .yday  (yday_reg),
        .leap  (leap_reg),
        .month (month_next),
        .day   (dom_next)
    );

    assign year_next = year_base_reg + YEAR_W'(yday_reg != '0);

    always_ff @(posedge aclk) begin
        if (adv4) begin
            year_reg  <= year_next;
            month_reg <= month_next;
            dom_reg   <= dom_next;
            wday4_reg <= wday3_reg;
        end
    end

    assign m_year         = year_reg;
    assign m_month        = month_reg;
    assign m_day_of_month = dom_reg;
    assign m_weekday      = wday4_reg;

`ifndef ASSERT_OFF
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month <= MONTH_DEC))
        else $error("month index out of range");

    a_dom_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day_of_month != '0))
        else $error("day of month is zero");

    a_feb_days: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_month == MONTH_FEB)) |-> (m_day_of_month <= 5'd29))
        else $error("February day past 29");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_weekday != 3'd7))
        else $error("weekday residue not reduced");
`endif

endmodule

>>> tb/calendar_date_checker.sv
`timescale 1ns / 1ps

module calendar_date_checker import dcd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [DAYS_W-1:0]  s_days_since_epoch,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [YEAR_W-1:0]  m_year,
    input  logic [MONTH_W-1:0] m_month,
    input  logic [DOM_W-1:0]   m_day_of_month,
    input  logic [WDAY_W-1:0]  m_weekday,

    output int                 mismatch_count,
    output int                 pending_count
);

    localparam int unsigned EPOCH_SHIFT      = 366;   // 1969-01-01 becomes day 1
    localparam int unsigned LEAP_CYCLE_DAYS  = 1461;
    localparam int unsigned COMMON_YEAR_DAYS = 365;
    localparam int unsigned CYCLE_BASE_YEAR  = 1968;
    localparam int unsigned LAST_YEAR_IDX    = 3;     // leap year of each cycle
    localparam int unsigned WEEK_DAYS        = 7;
    localparam int unsigned WEEKDAY_BIAS     = 2;
    localparam int unsigned DECEMBER         = 11;
    localparam int unsigned DEC_LAST_DAY     = 31;

    // cumulative month ends of a common year, [0] is January
    localparam logic [11:0][8:0] COMMON_MONTH_END = {
        9'd365, 9'd334, 9'd304, 9'd273, 9'd243, 9'd212,
        9'd181, 9'd151, 9'd120, 9'd90,  9'd59,  9'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
        logic [WDAY_W-1:0]  weekday;
    } cal_date_t;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        cal_date_t         date;
    } dated_day_t;

    dated_day_t expected_dates[$];
    int         errors = 0;

    function automatic cal_date_t civil_date_of(input logic [DAYS_W-1:0] days);
        cal_date_t   r;
        int unsigned shifted;
        int unsigned cycle_idx;
        int unsigned cycle_day;
        int unsigned year_idx;
        int unsigned year_day;
        int unsigned leap_extra;
        int unsigned prev_end;
        int unsigned month_end;
        logic        found;
        shifted   = int'(days) + EPOCH_SHIFT;
        cycle_idx = shifted / LEAP_CYCLE_DAYS;
        cycle_day = shifted - cycle_idx * LEAP_CYCLE_DAYS;
        year_idx  = cycle_day / COMMON_YEAR_DAYS;
        // cap keeps the last day but one of a leap year inside that year
        if (year_idx > LAST_YEAR_IDX)
            year_idx = LAST_YEAR_IDX;
        year_day = cycle_day - year_idx * COMMON_YEAR_DAYS;
        r.month        = MONTH_W'(DECEMBER);
        r.day_of_month = DOM_W'(DEC_LAST_DAY);
        if (year_day == 0) begin
            // year boundary on the shifted scale: 31 Dec of the year before
            r.year = YEAR_W'(4 * cycle_idx + year_idx + CYCLE_BASE_YEAR);
        end else begin
            leap_extra = (year_idx == LAST_YEAR_IDX) ? 1 : 0;
            prev_end   = 0;
            found      = 1'b0;
            r.year     = YEAR_W'(4 * cycle_idx + year_idx + 1 + CYCLE_BASE_YEAR);
            for (int i = 0; i < 12; i++) begin
                month_end = COMMON_MONTH_END[i] + ((i >= 1) ? leap_extra : 0);
                if (!found && year_day <= month_end) begin
                    r.month        = MONTH_W'(i);
                    r.day_of_month = DOM_W'(year_day - prev_end);
                    found          = 1'b1;
                end
                prev_end = month_end;
            end
        end
        r.weekday = WDAY_W'((shifted + WEEKDAY_BIAS) % WEEK_DAYS);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        dated_day_t want;
        dated_day_t seen;
        cal_date_t  got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.days      = s_days_since_epoch;
                seen.date      = civil_date_of(s_days_since_epoch);
                expected_dates = {expected_dates, seen};
            end
            if (m_valid && m_ready) begin
                got = {m_year, m_month, m_day_of_month, m_weekday};
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected date beat %0d-%0d-%0d wd %0d", $time,
                             got.year, got.month, got.day_of_month, got.weekday);
                    errors++;
                end else begin
                    want = expected_dates.pop_front();
                    if (want.date.year !== got.year || want.date.month !== got.month ||
                        want.date.day_of_month !== got.day_of_month ||
                        want.date.weekday !== got.weekday) begin
                        $display({"%0t: day %0d expected %0d-%0d-%0d wd %0d,",
                                  " got %0d-%0d-%0d wd %0d"},
                                 $time, want.days, want.date.year, want.date.month,
                                 want.date.day_of_month, want.date.weekday,
                                 got.year, got.month, got.day_of_month, got.weekday);
                        errors++;
                    end
                end
            end
        end
        mismatch_count <= errors;
        pending_count  <= expected_dates.size();
    end

endmodule

>>> tb/day_count_to_calendar_date_unit_tb.sv
`timescale 1ns / 1ps

module day_count_to_calendar_date_unit_tb;
    import dcd_pkg::*;

    // run ends here no matter what; a correct run needs a small fraction of it
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_DAYS  = 1600;
    localparam int DRAIN_CYCLES = 24;     // pipeline is four stages deep

    // receiver stall patterns
    typedef enum int {RX_STREAM, RX_RANDOM, RX_CHOKED} rx_mode_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [DAYS_W-1:0]  s_days_since_epoch = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [YEAR_W-1:0]  m_year;
    logic [MONTH_W-1:0] m_month;
    logic [DOM_W-1:0]   m_day_of_month;
    logic [WDAY_W-1:0]  m_weekday;

    int                 mismatch_count;
    int                 pending_count;
    int                 cycle_count = 0;

    rx_mode_t           rx_mode  = RX_STREAM;
    int                 rx_left  = 0;

    logic [DAYS_W-1:0]  day_plan[$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    day_count_to_calendar_date_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_days_since_epoch (s_days_since_epoch),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_year             (m_year),
        .m_month            (m_month),
        .m_day_of_month     (m_day_of_month),
        .m_weekday          (m_weekday)
    );

    // predicts every accepted day count and compares each result beat
    calendar_date_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_days_since_epoch (s_days_since_epoch),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_year             (m_year),
        .m_month            (m_month),
        .m_day_of_month     (m_day_of_month),
        .m_weekday          (m_weekday),
        .mismatch_count     (mismatch_count),
        .pending_count      (pending_count)
    );

    // Result side backpressure: hold one pattern for a random stretch, then
    // pick another. Full streaming, coin-flip ready, and mostly stalled.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_left <= $urandom_range(16, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("day_count_to_calendar_date_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int                idx;
        int                burst;
        int                near_day;
        int                year_off;
        logic [DAYS_W-1:0] pick;

        // Directed days:
        //   0..6        first week, every weekday once (epoch is a Thursday)
        //   58, 59      end of Feb / start of Mar in a common year
        //   364, 365    last day of 1970, first of 1971
        //   789, 790    29 Feb 1972 and the day after
        //   1094        30 Dec of a leap year, the capped year index
        //   1095, 1096  four-year boundary: 31 Dec 1972, then 1 Jan 1973
        //   47541       29 Feb 2100, leap under the plain four-year rule
        //   rest        field extremes and alternating bit patterns
        day_plan = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6,
                     16'd58, 16'd59, 16'd364, 16'd365, 16'd789, 16'd790,
                     16'd1094, 16'd1095, 16'd1096, 16'd47541,
                     16'd65534, 16'd65535, 16'd32768, 16'h5555, 16'hAAAA};

        // Random days: mostly uniform over the field, the rest clustered around
        // year starts and leap days, where the month table and the cap bite.
        for (int n = 0; n < RANDOM_DAYS; n++) begin
            if ($urandom_range(0, 9) < 6) begin
                pick = DAYS_W'($urandom_range(0, 65535));
            end else begin
                year_off = int'($urandom_range(0, 4));
                year_off = (year_off < 4) ? 365 * year_off : 1095 + 59;
                near_day = int'($urandom_range(0, 45)) * 1461 + year_off - 366
                         + int'($urandom_range(0, 6)) - 3;
                if (near_day < 0 || near_day > 65535)
                    near_day = int'($urandom_range(0, 65535));
                pick = DAYS_W'(near_day);
            end
            day_plan = {day_plan, pick};
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender: bursts of back-to-back beats, random gaps between bursts.
        // Valid stays up across a burst boundary when no gap is drawn.
        idx = 0;
        while (idx < day_plan.size()) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < day_plan.size()) begin
                s_valid            <= 1'b1;
                s_days_since_epoch <= day_plan[idx];
                do @(posedge aclk); while (!s_ready);
                idx++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        // drain, then give stray beats a chance to show up
        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("day_count_to_calendar_date_unit_tb: PASS");
        end else begin
            $display("day_count_to_calendar_date_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/dcd_pkg.sv
rtl/dcd_month_lookup.sv
rtl/day_count_to_calendar_date_unit.sv
tb/calendar_date_checker.sv
tb/day_count_to_calendar_date_unit_tb.sv
